// ===== rtl/core/dbps_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA best page size finder package
// Shared widths, register indexes, reset values, stage types and bit helpers.
// ----------------------------------------------------------------------------
package dbps_pkg;

   localparam int unsigned AddrWidth    = 64;
   localparam int unsigned LenWidth     = 32;
   localparam int unsigned OffWidth     = 12;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 64;

   localparam int unsigned PageShiftBitsDefault = 12;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CsrPageSizeBitmap = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrStartIova      = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRegionLength   = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrFirstOffset    = 2'd3;

   // Register reset values
   localparam logic [AddrWidth-1:0] BitmapReset    = 64'd4096;
   localparam logic [AddrWidth-1:0] StartIovaReset = 64'd0;
   localparam logic [AddrWidth-1:0] RegionLenReset = 64'd1;
   localparam logic [OffWidth-1:0]  FirstOffReset  = 12'd0;

   typedef struct packed {
      logic [AddrWidth-1:0] bitmap;
      logic [AddrWidth-1:0] start_iova;
      logic [AddrWidth-1:0] region_length;
      logic [OffWidth-1:0]  first_offset;
   } csr_type;

   // Final mask of a region and the supported sizes at its last entry
   typedef struct packed {
      logic [AddrWidth-1:0] diff;
      logic [AddrWidth-1:0] bitmap;
   } fin_type;

   // Fill every bit below the highest set bit
   function automatic logic [AddrWidth-1:0] smear_right(input logic [AddrWidth-1:0] x);
      logic [AddrWidth-1:0] s;
      s = x;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      s = s | (s >> 32);
      return s;
   endfunction

endpackage

// ===== rtl/core/dbps_req_if.sv =====
// ----------------------------------------------------------------------------
// Scatter-gather entry channel
// Valid/ready channel carrying one scatter-gather entry per beat.
// ----------------------------------------------------------------------------
interface dbps_req_if;
   logic                            valid;
   logic                            ready;
   logic [dbps_pkg::AddrWidth-1:0]  dma_address;
   logic [dbps_pkg::LenWidth-1:0]   dma_length;
   logic                            last_entry;

   modport source (output valid, dma_address, dma_length, last_entry, input ready);
   modport sink   (input valid, dma_address, dma_length, last_entry, output ready);
endinterface

// ===== rtl/core/dbps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Page size result channel
// Valid/ready channel carrying one chosen page size per beat.
// ----------------------------------------------------------------------------
interface dbps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dbps_pkg::AddrWidth-1:0]  best_size;

   modport source (output valid, best_size, input ready);
   modport sink   (input valid, best_size, output ready);
endinterface

// ===== rtl/core/dbps_accum.sv =====
// ----------------------------------------------------------------------------
// Region mask accumulator
// Registers each entry beat and folds it into the running mask and IOVA.
// ----------------------------------------------------------------------------
module dbps_accum #(
   parameter int unsigned PAGE_SHIFT_BITS = dbps_pkg::PageShiftBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  dbps_pkg::csr_type csr,
   dbps_req_if.sink          req,
   output logic              fin_valid,
   output dbps_pkg::fin_type fin_data,
   input  logic              fin_ready
);
   import dbps_pkg::*;

   localparam logic [AddrWidth-1:0] PgOffMask =
      (64'd1 << PAGE_SHIFT_BITS) - 64'd1;

   logic                 s1_valid_ff, s1_valid_in;
   logic [AddrWidth-1:0] addr_ff;
   logic [LenWidth-1:0]  len_ff;
   logic                 last_ff;

   logic [AddrWidth-1:0] diff_ff, diff_in;
   logic [AddrWidth-1:0] iova_ff, iova_in;
   logic                 first_ff;

   logic                 s1_go;
   logic                 accept;
   logic [AddrWidth-1:0] span;
   logic [AddrWidth-1:0] keep;
   logic [AddrWidth-1:0] base_diff;
   logic [AddrWidth-1:0] base_iova;
   logic [AddrWidth-1:0] pgoff;
   logic [AddrWidth-1:0] mixed;

   // Handshake: non-last beats never wait on the final stage
   assign s1_go     = s1_valid_ff && (!last_ff || fin_ready);
   assign req.ready = !s1_valid_ff || s1_go;
   assign accept    = req.valid && req.ready;

   // Seed mask: supported sizes above the span of touched IOVA bits
   assign span = (csr.region_length - 64'd1 + csr.start_iova) ^ csr.start_iova;
   assign keep = ~(smear_right(span) | 64'd1);

   // Fold the entry into the running mask and IOVA
   always_comb begin
      if (first_ff) begin
         base_diff = csr.bitmap & keep;
         base_iova = csr.start_iova;
         pgoff     = {{(AddrWidth-OffWidth){1'b0}}, csr.first_offset} & PgOffMask;
      end else begin
         base_diff = diff_ff;
         base_iova = iova_ff;
         pgoff     = '0;
      end
      mixed   = base_diff | ((addr_ff + pgoff) ^ base_iova);
      iova_in = base_iova + {{(AddrWidth-LenWidth){1'b0}}, len_ff} - pgoff;
      diff_in = last_ff ? mixed : (mixed | iova_in);
   end

   assign fin_valid       = s1_valid_ff && last_ff;
   assign fin_data.diff   = mixed;
   assign fin_data.bitmap = csr.bitmap;

   // Hold or advance the entry register
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req.dma_address;
         len_ff  <= req.dma_length;
         last_ff <= req.last_entry;
      end
   end

   // Update region state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff  <= '0;
         iova_ff  <= '0;
         first_ff <= 1'b1;
      end else if (s1_go) begin
         diff_ff  <= diff_in;
         iova_ff  <= iova_in;
         first_ff <= last_ff;
      end
   end

   a_mid_never_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !last_ff) |-> s1_go)
      else $error("non-last entry held in accumulator");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (s1_go && last_ff) |=> first_ff)
      else $error("region not reopened after last entry");

endmodule

// ===== rtl/core/dbps_pick.sv =====
// ----------------------------------------------------------------------------
// Page size picker
// Cuts the supported sizes at the mask's lowest set bit and keeps the largest.
// ----------------------------------------------------------------------------
module dbps_pick (
   input  logic              clock,
   input  logic              reset,
   input  logic              fin_valid,
   input  dbps_pkg::fin_type fin_data,
   output logic              fin_ready,
   dbps_rsp_if.source        rsp
);
   import dbps_pkg::*;

   logic                 s2_valid_ff, s2_valid_in;
   fin_type              s2_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AddrWidth-1:0] best_size_ff;

   logic                 out_free;
   logic                 s2_go;
   logic [AddrWidth-1:0] low_bit;
   logic [AddrWidth-1:0] upto;
   logic [AddrWidth-1:0] sizes;
   logic [AddrWidth-1:0] top;

   // Handshake through the final and output registers
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s2_go     = s2_valid_ff && out_free;
   assign fin_ready = !s2_valid_ff || s2_go;

   // Sizes up to the lowest set bit; an empty mask cuts nothing
   assign low_bit = s2_ff.diff & (~s2_ff.diff + 64'd1);
   assign upto    = low_bit | (low_bit - 64'd1);
   assign sizes   = s2_ff.bitmap & upto;
   assign top     = sizes & ~(smear_right(sizes) >> 1);

   assign s2_valid_in  = (fin_valid && fin_ready) ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = s2_go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         s2_ff <= fin_data;
      end
      if (s2_go) begin
         best_size_ff <= top;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.best_size = best_size_ff;

   a_pick_lands: assert property (@(posedge clock) disable iff (reset)
      s2_go |=> rsp_valid_ff)
      else $error("picked size did not reach output register");

endmodule

// ===== rtl/core/dma_best_page_size_finder.sv =====
// ----------------------------------------------------------------------------
// DMA best page size finder
// Finds the largest supported page size that maps a scatter-gather region.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                          | handshake
//  --------+-----+----------------------------------------+-----------------
//  csr_    | in  | csr_index, csr_wdata                   | csr_wr_en
//  req     | in  | dma_address, dma_length, last_entry    | valid / ready
//  rsp     | out | best_size                              | valid / ready
//
//  One entry beat per cycle while req.ready is high. A last entry's page
//  size is presented on rsp after the entry, final and output registers.
//  Non-last entries only update the running mask and IOVA; once registered
//  they never wait on rsp. A stalled rsp backs up through the final register
//  into req.ready. Reset is synchronous: state and CSR registers return to
//  their reset values and the next entry opens a new region.
// ----------------------------------------------------------------------------
module dma_best_page_size_finder #(
   parameter int unsigned PAGE_SHIFT_BITS = dbps_pkg::PageShiftBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [dbps_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [dbps_pkg::CsrDataWidth-1:0]  csr_wdata,
   dbps_req_if.sink                           req,
   dbps_rsp_if.source                         rsp
);
   import dbps_pkg::*;

   logic [AddrWidth-1:0] bitmap_ff;
   logic [AddrWidth-1:0] start_iova_ff;
   logic [AddrWidth-1:0] region_len_ff;
   logic [OffWidth-1:0]  first_off_ff;

   csr_type csr;
   logic    fin_valid;
   logic    fin_ready;
   fin_type fin_data;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff     <= BitmapReset;
         start_iova_ff <= StartIovaReset;
         region_len_ff <= RegionLenReset;
         first_off_ff  <= FirstOffReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrPageSizeBitmap: bitmap_ff     <= csr_wdata;
            CsrStartIova:      start_iova_ff <= csr_wdata;
            CsrRegionLength:   region_len_ff <= csr_wdata;
            CsrFirstOffset:    first_off_ff  <= csr_wdata[OffWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr.bitmap        = bitmap_ff;
   assign csr.start_iova    = start_iova_ff;
   assign csr.region_length = region_len_ff;
   assign csr.first_offset  = first_off_ff;

   dbps_accum #(
      .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req       (req),
      .fin_valid (fin_valid),
      .fin_data  (fin_data),
      .fin_ready (fin_ready)
   );

   dbps_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_data  (fin_data),
      .fin_ready (fin_ready),
      .rsp       (rsp)
   );

   a_single_size: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot0(rsp.best_size))
      else $error("page size is not a single power of two");

endmodule
